// ===== rtl/core/wmoc_pkg.sv =====
// Shared types and constants for the weighted mean and outlier clip block.
// Used by the channel interfaces, the divider and the top level. No dependencies.
`timescale 1ns / 1ps

package wmoc_pkg;

  localparam int WORD_W             = 32;
  localparam int ACC_W              = 64;
  localparam int DEF_MAX_DETECTIONS = 64;

  localparam logic [WORD_W-1:0] SIG_THR_RESET = 32'd196608;
  localparam logic [62:0]       SAT63         = {63{1'b1}};

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    logic signed [31:0] magnitude;
    word_t              weight;
    word_t              clip_weight;
    logic               clipped;
    logic               last_item;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] mean_value;
    logic [37:0]        total_weight;
    logic [62:0]        chi_square;
    logic [62:0]        max_deviation_sq;
    logic [5:0]         degrees_freedom;
    logic [6:0]         fit_count;
    logic               clip_found;
    logic [5:0]         clip_index;
  } out_item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== rtl/core/wmoc_if.sv =====
// Valid/ready channel interfaces for detection requests and group results.
// Depends on wmoc_pkg for the payload types.
`timescale 1ns / 1ps

interface wmoc_in_if;
  import wmoc_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface wmoc_out_if;
  import wmoc_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/wmoc_divider.sv =====
// Restoring unsigned divider, one quotient bit per cycle over the 64-bit dividend.
// Depends on wmoc_pkg for widths and the status struct.
`timescale 1ns / 1ps

module wmoc_divider #(
  parameter int DEN_W = wmoc_pkg::WORD_W + 6
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [wmoc_pkg::ACC_W-1:0] dividend,
  input  logic [DEN_W-1:0]           divisor,
  output logic [wmoc_pkg::ACC_W-1:0] quotient,
  output wmoc_pkg::div_stat_t        stat
);
  import wmoc_pkg::*;

  localparam int CNT_W = $clog2(ACC_W);

  logic [ACC_W-1:0] dq_r;
  logic [DEN_W-1:0] rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DEN_W:0]   trial;
  logic             fits;

  // The dividend shifts out at the top while quotient bits shift in at the bottom.
  assign trial = {rem_r, dq_r[ACC_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(ACC_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq_r  <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= fits ? DEN_W'(trial - {1'b0, divisor}) : trial[DEN_W-1:0];
      dq_r  <= {dq_r[ACC_W-2:0], fits};
    end
  end

  assign quotient  = dq_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// ===== rtl/core/weighted_mean_outlier_clip.sv =====
// Top level: weighted mean, chi-square and worst-outlier search over one group.
// Depends on wmoc_pkg, the channel interfaces in wmoc_if and wmoc_divider.
//
//   Channel   Direction  Handshake     Carries
//   in_chan   sink       valid/ready   one detection request per accept
//   out_chan  source     valid/ready   one result per group, on last_item
//   cfg_*     input      write enable  sig_threshold
// Detections load at one per cycle into a local store while in the load state.
// After last_item the block is busy: the settle, the 64-step divider if one fits
// and, if two or more fit, the threshold square and a pass over each stored
// detection, longer for a fitting one; all products use one shared 33x33
// multiplier. A finished result waits in the output register, so the next group
// loads while it stalls; a second result waits until it is taken.
// Reset is synchronous and active low; no clearing pass is needed.
`timescale 1ns / 1ps

module weighted_mean_outlier_clip #(
  parameter int MAX_DETECTIONS = wmoc_pkg::DEF_MAX_DETECTIONS
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  wmoc_pkg::word_t cfg_wdata,
  wmoc_in_if.sink         in_chan,
  wmoc_out_if.source      out_chan
);
  import wmoc_pkg::*;

  localparam int CW  = $clog2(MAX_DETECTIONS + 1);
  localparam int AW  = $clog2(MAX_DETECTIONS);
  localparam int WSW = WORD_W + AW;

  localparam logic [3:0] S_LOAD   = 4'd0;
  localparam logic [3:0] S_SETTLE = 4'd1;
  localparam logic [3:0] S_DIV    = 4'd2;
  localparam logic [3:0] S_MEAN   = 4'd3;
  localparam logic [3:0] S_THR    = 4'd4;
  localparam logic [3:0] S_RD     = 4'd5;
  localparam logic [3:0] S_AD     = 4'd6;
  localparam logic [3:0] S_SQ     = 4'd7;
  localparam logic [3:0] S_WLO    = 4'd8;
  localparam logic [3:0] S_WHI    = 4'd9;
  localparam logic [3:0] S_WCB    = 4'd10;
  localparam logic [3:0] S_ACC    = 4'd11;
  localparam logic [3:0] S_CWHI   = 4'd12;
  localparam logic [3:0] S_CCB    = 4'd13;
  localparam logic [3:0] S_CMP    = 4'd14;
  localparam logic [3:0] S_FIN    = 4'd15;

  typedef struct packed {
    logic               fit;
    word_t              clip_weight;
    word_t              weight;
    logic signed [31:0] magnitude;
  } entry_t;

  logic [3:0]      state_r, state_nxt;
  word_t           sig_thr_r;
  logic [CW-1:0]   item_cnt_r;
  logic [CW-1:0]   fit_cnt_r;
  logic [CW-1:0]   pi_r;
  logic [CW-1:0]   idx_r;
  logic [ACC_W-1:0] wsum_r;
  logic [WSW-1:0]  wts_r;
  logic            acc_pend_r;
  logic            div_start_r;
  logic            out_valid_r;
  out_item_t       out_r;

  entry_t          mem_r [MAX_DETECTIONS];
  entry_t          rd_ent_r;
  entry_t          wr_ent;

  logic [ACC_W-1:0] prod_r;
  logic [ACC_W-1:0] sq_r;
  logic [ACC_W-1:0] pl_r;
  logic [ACC_W-1:0] ph_r;
  logic [ACC_W-1:0] thr2_r;
  logic [ACC_W-1:0] dev_r;
  logic [ACC_W-1:0] best_r;
  logic [62:0]     termw_r;
  logic [62:0]     chi_r;
  logic [62:0]     max_r;
  logic [31:0]     ad_r;
  logic signed [31:0] mean_r;
  logic            found_r;

  logic            in_fire;
  logic            room;
  logic            fit_in;
  logic            fin_go;
  logic            last_pos;
  logic            multi_fit;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic [ACC_W-1:0]   mul_lo;

  logic [ACC_W-1:0] wsum_add;
  logic             wsum_ovf;
  logic [ACC_W-1:0] wsum_sat;

  logic [ACC_W-1:0] div_dividend;
  logic [ACC_W-1:0] div_quot;
  div_stat_t        div_stat;

  logic signed [32:0] diff;
  logic [32:0]        diff_abs;
  logic [64:0]        upper;
  logic               over;
  logic [ACC_W-1:0]   scaled;
  logic [62:0]        term_w;
  logic [ACC_W-1:0]   term_c;
  logic [ACC_W-1:0]   chi_sum;
  logic signed [31:0] mean_c;

  assign in_chan.ready = (state_r == S_LOAD);
  assign in_fire       = in_chan.valid && (state_r == S_LOAD);
  assign room          = item_cnt_r < CW'(MAX_DETECTIONS);
  assign fit_in        = !in_chan.data.clipped && (in_chan.data.weight != '0);
  assign fin_go        = (state_r == S_FIN) && (!out_valid_r || out_chan.ready);
  assign last_pos      = (pi_r + CW'(1)) == item_cnt_r;
  assign multi_fit     = fit_cnt_r > CW'(1);

  assign wr_ent.fit         = fit_in;
  assign wr_ent.clip_weight = in_chan.data.clip_weight;
  assign wr_ent.weight      = in_chan.data.weight;
  assign wr_ent.magnitude   = in_chan.data.magnitude;

  // Shared multiplier: operands are widened to 33 bits so that the signed load
  // product and the unsigned partial products use the same unit.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_LOAD: begin
        mul_a = {in_chan.data.magnitude[31], in_chan.data.magnitude};
        mul_b = {1'b0, in_chan.data.weight};
      end
      S_THR: begin
        mul_a = {1'b0, sig_thr_r};
        mul_b = {1'b0, sig_thr_r};
      end
      S_SQ: begin
        mul_a = {1'b0, ad_r};
        mul_b = {1'b0, ad_r};
      end
      S_WLO: begin
        mul_a = {1'b0, sq_r[31:0]};
        mul_b = {1'b0, rd_ent_r.weight};
      end
      S_WHI: begin
        mul_a = {1'b0, sq_r[63:32]};
        mul_b = {1'b0, rd_ent_r.weight};
      end
      S_ACC: begin
        mul_a = {1'b0, sq_r[31:0]};
        mul_b = {1'b0, rd_ent_r.clip_weight};
      end
      S_CWHI: begin
        mul_a = {1'b0, sq_r[63:32]};
        mul_b = {1'b0, rd_ent_r.clip_weight};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p  = mul_a * mul_b;
  assign mul_lo = mul_p[63:0];

  // Saturating signed accumulation of the registered load product.
  assign wsum_add = wsum_r + prod_r;
  assign wsum_ovf = (wsum_r[63] == prod_r[63]) && (wsum_add[63] != wsum_r[63]);
  assign wsum_sat = wsum_ovf ? (wsum_r[63] ? {1'b1, 63'd0} : {1'b0, SAT63}) : wsum_add;

  assign div_dividend = wsum_r[63] ? ACC_W'(-wsum_r) : wsum_r;

  wmoc_divider #(
    .DEN_W (WSW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (div_dividend),
    .divisor  (wts_r),
    .quotient (div_quot),
    .stat     (div_stat)
  );

  // The quotient is a magnitude; the sign of the weighted sum is applied here.
  always_comb begin
    if (wsum_r[63]) begin
      mean_c = (div_quot > 64'h8000_0000) ? 32'sh8000_0000 : 32'(-div_quot[31:0]);
    end else begin
      mean_c = (div_quot > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(div_quot[31:0]);
    end
  end

  assign diff     = {rd_ent_r.magnitude[31], rd_ent_r.magnitude} - {mean_r[31], mean_r};
  assign diff_abs = diff[32] ? 33'(-diff) : 33'(diff);

  // Joins the two partial products of sq * w and drops the 16 fraction bits.
  assign upper   = {1'b0, ph_r} + {33'd0, pl_r[63:32]};
  assign over    = |upper[64:48];
  assign scaled  = {upper[47:0], pl_r[31:16]};
  assign term_w  = (over || scaled[63]) ? SAT63 : scaled[62:0];
  assign term_c  = over ? {ACC_W{1'b1}} : scaled;
  assign chi_sum = {1'b0, chi_r} + {1'b0, termw_r};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_LOAD: begin
        if (in_fire && in_chan.data.last_item) state_nxt = S_SETTLE;
      end
      S_SETTLE: state_nxt = (fit_cnt_r == '0) ? S_FIN : S_DIV;
      S_DIV: begin
        if (div_stat.done) state_nxt = S_MEAN;
      end
      S_MEAN:   state_nxt = multi_fit ? S_THR : S_FIN;
      S_THR:    state_nxt = S_RD;
      S_RD:     state_nxt = S_AD;
      S_AD: begin
        if (rd_ent_r.fit) begin
          state_nxt = S_SQ;
        end else begin
          state_nxt = last_pos ? S_FIN : S_RD;
        end
      end
      S_SQ:     state_nxt = S_WLO;
      S_WLO:    state_nxt = S_WHI;
      S_WHI:    state_nxt = S_WCB;
      S_WCB:    state_nxt = S_ACC;
      S_ACC:    state_nxt = S_CWHI;
      S_CWHI:   state_nxt = S_CCB;
      S_CCB:    state_nxt = S_CMP;
      S_CMP:    state_nxt = last_pos ? S_FIN : S_RD;
      S_FIN: begin
        if (fin_go) state_nxt = S_LOAD;
      end
      default:  state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      sig_thr_r   <= SIG_THR_RESET;
      item_cnt_r  <= '0;
      fit_cnt_r   <= '0;
      wsum_r      <= '0;
      wts_r       <= '0;
      acc_pend_r  <= 1'b0;
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_pend_r  <= in_fire && room && !in_chan.data.clipped;
      div_start_r <= (state_r == S_SETTLE) && (fit_cnt_r != '0) && !div_stat.busy;
      if (cfg_we) sig_thr_r <= cfg_wdata;
      if (fin_go) begin
        item_cnt_r <= '0;
        fit_cnt_r  <= '0;
        wsum_r     <= '0;
        wts_r      <= '0;
      end else begin
        if (acc_pend_r) wsum_r <= wsum_sat;
        if (in_fire && room) begin
          item_cnt_r <= item_cnt_r + CW'(1);
          if (fit_in) fit_cnt_r <= fit_cnt_r + CW'(1);
          if (!in_chan.data.clipped) wts_r <= wts_r + WSW'(in_chan.data.weight);
        end
      end
      if (fin_go) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && room) mem_r[item_cnt_r[AW-1:0]] <= wr_ent;
    rd_ent_r <= mem_r[pi_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_LOAD: begin
        if (in_fire) prod_r <= mul_lo;
      end
      S_SETTLE: begin
        chi_r   <= '0;
        max_r   <= '0;
        best_r  <= '0;
        found_r <= 1'b0;
        idx_r   <= '0;
      end
      S_MEAN:  mean_r <= mean_c;
      S_THR: begin
        thr2_r <= mul_lo;
        pi_r   <= '0;
      end
      S_AD: begin
        ad_r <= diff_abs[31:0];
        if (!rd_ent_r.fit) pi_r <= pi_r + CW'(1);
      end
      S_SQ:    sq_r <= mul_lo;
      S_WLO:   pl_r <= mul_lo;
      S_WHI:   ph_r <= mul_lo;
      S_WCB:   termw_r <= term_w;
      S_ACC: begin
        chi_r <= chi_sum[63] ? SAT63 : chi_sum[62:0];
        if (termw_r > max_r) max_r <= termw_r;
        pl_r <= mul_lo;
      end
      S_CWHI:  ph_r <= mul_lo;
      S_CCB:   dev_r <= term_c;
      S_CMP: begin
        // Strict compare keeps the first of equal deviations.
        if ((dev_r > thr2_r) && (dev_r > best_r)) begin
          best_r  <= dev_r;
          idx_r   <= pi_r;
          found_r <= 1'b1;
        end
        pi_r <= pi_r + CW'(1);
      end
      S_FIN: begin
        if (fin_go) begin
          out_r.mean_value       <= (fit_cnt_r != '0) ? mean_r : '0;
          out_r.total_weight     <= (fit_cnt_r != '0) ? 38'(wts_r) : '0;
          out_r.chi_square       <= chi_r;
          out_r.max_deviation_sq <= max_r;
          out_r.degrees_freedom  <= multi_fit ? 6'(fit_cnt_r - CW'(1)) : '0;
          out_r.fit_count        <= 7'(fit_cnt_r);
          out_r.clip_found       <= found_r;
          out_r.clip_index       <= found_r ? 6'(idx_r) : '0;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_r;

endmodule

// ===== tb/weighted_mean_outlier_clip_tb.sv =====
// Self-checking testbench for weighted_mean_outlier_clip: directed groups, overflow groups
// and random groups under several clip thresholds, checked against a predictor of its own.
// Depends on wmoc_pkg, the channel interfaces in wmoc_if and the top level of the block.
`timescale 1ns / 1ps

module weighted_mean_outlier_clip_tb;
  import wmoc_pkg::*;

  localparam int          WATCHDOG_LIMIT = 5000;
  localparam int          CFG_SETTLE     = 100;
  localparam int          END_SETTLE     = 200;
  localparam int          PHASE_ITEMS    = 90;
  localparam logic [31:0] ONE            = 32'h0001_0000;
  localparam logic [63:0] CHI_CAP        = {1'b0, SAT63};
  localparam logic [63:0] DEV_CAP        = {64{1'b1}};

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  word_t       cfg_wdata;

  wmoc_in_if  in_chan ();
  wmoc_out_if out_chan ();

  weighted_mean_outlier_clip u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Predictor state: one group in flight plus the threshold last written.
  logic signed [31:0] mag_mem [DEF_MAX_DETECTIONS];
  logic [31:0]        wt_mem  [DEF_MAX_DETECTIONS];
  logic [31:0]        cw_mem  [DEF_MAX_DETECTIONS];
  bit                 fit_mem [DEF_MAX_DETECTIONS];
  logic signed [63:0] wsum      = '0;
  logic [63:0]        wtot      = '0;
  int unsigned        grp_items = 0;
  int unsigned        grp_fit   = 0;
  logic [31:0]        thr_model = SIG_THR_RESET;

  out_item_t pending_results [$];
  int        mismatches  = 0;
  int        idle_cycles = 0;
  int        burst_left  = 0;
  bit        sender_gaps = 1'b1;
  bit        rx_stalls   = 1'b1;
  bit        rx_state    = 1'b1;
  int        rx_run      = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64:63] == 2'b01) return {1'b0, {63{1'b1}}};
    if (s[64:63] == 2'b10) return {1'b1, 63'b0};
    return s[63:0];
  endfunction

  // Exact ad*ad*w in Q48.48, floored to Q32.32 and capped.
  function automatic logic [63:0] weighted_square(input logic [33:0] ad, input logic [31:0] w,
                                                  input logic [63:0] cap);
    logic [127:0] prod;
    prod = 128'(ad) * 128'(ad) * 128'(w);
    prod = prod >> 16;
    return (prod > 128'(cap)) ? cap : prod[63:0];
  endfunction

  function automatic logic signed [63:0] group_mean();
    logic [63:0] mag_abs;
    logic [63:0] quot;
    if (wtot == 0) return '0;
    mag_abs = wsum[63] ? 64'd0 - wsum : wsum;
    quot = mag_abs / wtot;
    if (wsum[63]) begin
      if (quot > 64'h8000_0000) quot = 64'h8000_0000;
      return 64'd0 - quot;
    end
    if (quot > 64'h7FFF_FFFF) quot = 64'h7FFF_FFFF;
    return quot;
  endfunction

  function automatic void absorb_detection(input in_item_t det);
    logic signed [63:0] mag64, wt64, mean, resid;
    logic [63:0]        thr_sq, term, dev, chi, peak, best;
    logic [33:0]        ad;
    out_item_t          res;
    int unsigned        hit;
    bit                 found;
    bit                 fits;
    // Detections past the store depth are dropped, but a last mark still closes the group.
    if (grp_items < DEF_MAX_DETECTIONS) begin
      fits = !det.clipped && det.weight != 0;
      mag_mem[grp_items] = det.magnitude;
      wt_mem[grp_items]  = det.weight;
      cw_mem[grp_items]  = det.clip_weight;
      fit_mem[grp_items] = fits;
      if (!det.clipped) begin
        mag64 = det.magnitude;
        wt64  = {32'b0, det.weight};
        wsum  = sat_add64(wsum, mag64 * wt64);
        wtot  += det.weight;
      end
      if (fits) grp_fit++;
      grp_items++;
    end
    if (!det.last_item) return;

    res   = '0;
    mean  = '0;
    chi   = '0;
    peak  = '0;
    best  = '0;
    hit   = 0;
    found = 1'b0;
    if (grp_fit >= 1) begin
      mean = group_mean();
      res.total_weight = wtot[37:0];
    end
    if (grp_fit >= 2) begin
      thr_sq = {32'b0, thr_model} * {32'b0, thr_model};
      for (int i = 0; i < grp_items; i++) begin
        if (!fit_mem[i]) continue;
        resid = mag_mem[i] - mean;
        ad    = (resid < 0) ? -resid : resid;
        term  = weighted_square(ad, wt_mem[i], CHI_CAP);
        if (term > peak) peak = term;
        chi = (chi > CHI_CAP - term) ? CHI_CAP : chi + term;
        dev = weighted_square(ad, cw_mem[i], DEV_CAP);
        // Strictly greater, so the earliest of equal outliers is kept.
        if (dev > thr_sq && dev > best) begin
          best  = dev;
          hit   = i;
          found = 1'b1;
        end
      end
      res.degrees_freedom = 6'(grp_fit - 1);
    end
    res.mean_value       = mean[31:0];
    res.chi_square       = chi[62:0];
    res.max_deviation_sq = peak[62:0];
    res.fit_count        = 7'(grp_fit);
    res.clip_found       = found;
    res.clip_index       = found ? 6'(hit) : 6'd0;
    pending_results.insert(pending_results.size(), res);
    wsum      = '0;
    wtot      = '0;
    grp_items = 0;
    grp_fit   = 0;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatches < 50)
      $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst_n && in_chan.valid && in_chan.ready) absorb_detection(in_chan.data);
  end

  always @(posedge clk) begin : result_check
    out_item_t got;
    out_item_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got = out_chan.data;
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request pending", got.mean_value, '0);
      end else begin
        want = pending_results.pop_front();
        if (got.mean_value !== want.mean_value)
          report_mismatch("mean_value", got.mean_value, want.mean_value);
        if (got.total_weight !== want.total_weight)
          report_mismatch("total_weight", got.total_weight, want.total_weight);
        if (got.chi_square !== want.chi_square)
          report_mismatch("chi_square", got.chi_square, want.chi_square);
        if (got.max_deviation_sq !== want.max_deviation_sq)
          report_mismatch("max_deviation_sq", got.max_deviation_sq, want.max_deviation_sq);
        if (got.degrees_freedom !== want.degrees_freedom)
          report_mismatch("degrees_freedom", got.degrees_freedom, want.degrees_freedom);
        if (got.fit_count !== want.fit_count)
          report_mismatch("fit_count", got.fit_count, want.fit_count);
        if (got.clip_found !== want.clip_found)
          report_mismatch("clip_found", got.clip_found, want.clip_found);
        if (got.clip_index !== want.clip_index)
          report_mismatch("clip_index", got.clip_index, want.clip_index);
      end
    end
  end

  // While stalls are on, the receiver alternates ready and stall runs, with the odd long stall.
  always @(posedge clk) begin
    if (!rx_stalls) begin
      out_chan.ready <= 1'b1;
    end else begin
      if (rx_run == 0) begin
        rx_state = !rx_state;
        if (rx_state) rx_run = $urandom_range(1, 10);
        else rx_run = ($urandom_range(0, 15) == 0) ? $urandom_range(30, 150)
                                                   : $urandom_range(1, 6);
      end
      rx_run--;
      out_chan.ready <= rx_state;
    end
  end

  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_detection(input logic signed [31:0] mag, input logic [31:0] w,
                                input logic [31:0] cw, input logic clp, input logic lst);
    int       gap;
    in_item_t item;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = 0;
      if (sender_gaps)
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 4);
      if (gap > 0) begin
        in_chan.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    item.magnitude   = mag;
    item.weight      = w;
    item.clip_weight = cw;
    item.clipped     = clp;
    item.last_item   = lst;
    in_chan.valid <= 1'b1;
    in_chan.data  <= item;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  task automatic idle_sender();
    in_chan.valid <= 1'b0;
    burst_left = 0;
  endtask

  // The first wait lets the request monitor see the final accept.
  task automatic wait_drain();
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [31:0] value);
    idle_sender();
    wait_drain();
    repeat (CFG_SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    thr_model = value;
  endtask

  task automatic send_random_group(input int len);
    int                 style;
    int                 noise;
    logic signed [31:0] centre;
    logic signed [31:0] mag;
    logic [31:0]        w, cw;
    logic               clp;
    style  = $urandom_range(0, 9);
    centre = $urandom();
    centre = {{4{centre[27]}}, centre[27:0]};
    for (int i = 0; i < len; i++) begin
      if (style < 7) begin
        noise = int'($urandom_range(0, 32'h3FFFF)) - 32'h1FFFF;
        if ($urandom_range(0, 7) == 0) noise = int'($urandom_range(0, 32'h7FFFFF)) - 32'h3FFFFF;
        mag = centre + noise;
        w   = $urandom_range(32'h4000, 32'h40000);
        cw  = $urandom_range(32'h4000, 32'h40000);
      end else begin
        mag = $urandom();
        w   = $urandom();
        cw  = $urandom();
      end
      clp = ($urandom_range(0, 9) == 0);
      if ($urandom_range(0, 19) == 0) w = '0;
      if ($urandom_range(0, 29) == 0) cw = '0;
      send_detection(mag, w, cw, clp, i == len - 1);
    end
  endtask

  task automatic test_directed_cases();
    sender_gaps = 1'b1;
    rx_stalls   = 1'b1;
    // A lone fitting detection at the field extremes: no chi-square, no clip.
    send_detection(32'sh7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1);
    // Nothing fits: one clipped detection and one with zero weight.
    send_detection(32'sh8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0);
    send_detection(32'sd12345, 32'h0, 32'hFFFF_FFFF, 1'b0, 1'b1);
    // The weighted sum saturates upwards, then downwards.
    repeat (2) send_detection(32'sh7FFF_FFFF, 32'hFFFF_FFFF, ONE, 1'b0, 1'b0);
    send_detection(32'sh7FFF_FFFF, 32'hFFFF_FFFF, ONE, 1'b0, 1'b1);
    repeat (2) send_detection(32'sh8000_0000, 32'hFFFF_FFFF, ONE, 1'b0, 1'b0);
    send_detection(32'sh8000_0000, 32'hFFFF_FFFF, ONE, 1'b0, 1'b1);
    // Opposite extremes: every term saturates, so the first detection wins the tie.
    send_detection(32'sh8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0);
    send_detection(32'sh7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1);
    // Identical magnitudes: zero residuals and no outlier.
    send_detection(-32'sh0003_8000, ONE, ONE, 1'b0, 1'b0);
    send_detection(-32'sh0003_8000, 32'h0002_0000, ONE, 1'b0, 1'b0);
    send_detection(-32'sh0003_8000, 32'h0000_8000, 32'h0004_0000, 1'b0, 1'b0);
    send_detection(-32'sh0003_8000, 32'h0000_0001, ONE, 1'b0, 1'b1);
    // One clear outlier in the middle of the group.
    repeat (3) send_detection(32'sh0001_0000, ONE, ONE, 1'b0, 1'b0);
    send_detection(32'sh0009_0000, ONE, ONE, 1'b0, 1'b0);
    send_detection(32'sh0001_0000, ONE, ONE, 1'b0, 1'b1);
    // The closing detection is itself clipped.
    send_detection(32'sh0001_0000, ONE, ONE, 1'b0, 1'b0);
    send_detection(32'sh0002_0000, ONE, ONE, 1'b0, 1'b0);
    send_detection(32'sh0064_0000, ONE, ONE, 1'b1, 1'b1);
  endtask

  task automatic test_group_overflow();
    send_random_group(DEF_MAX_DETECTIONS);
    send_random_group(DEF_MAX_DETECTIONS + 6);
  endtask

  task automatic test_random_groups();
    logic [31:0] thr_plan [5];
    int          sent;
    int          groups;
    int          len;
    int          pick;
    thr_plan = '{32'h0002_0000, 32'h0, 32'hFFFF_FFFF, 32'h0, SIG_THR_RESET};
    thr_plan[3] = $urandom();
    groups = 0;
    foreach (thr_plan[p]) begin
      write_threshold(thr_plan[p]);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 10) len = 1;
        else if (pick < 88) len = $urandom_range(2, 8);
        else if (pick < 98) len = $urandom_range(9, 40);
        else len = $urandom_range(60, 70);
        sender_gaps = ($urandom_range(0, 3) != 0);
        rx_stalls   = ($urandom_range(0, 3) != 0);
        send_random_group(len);
        sent += (len > DEF_MAX_DETECTIONS) ? DEF_MAX_DETECTIONS : len;
        groups++;
        // Now and then the sender holds off until every result is back.
        if (groups % 10 == 0) begin
          idle_sender();
          wait_drain();
        end
      end
    end
  endtask

  initial begin : main
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    in_chan.valid  = 1'b0;
    in_chan.data   = '0;
    out_chan.ready = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_group_overflow();
    test_random_groups();
    idle_sender();
    wait_drain();
    repeat (END_SETTLE) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/wmoc_pkg.sv
rtl/core/wmoc_if.sv
rtl/core/wmoc_divider.sv
rtl/core/weighted_mean_outlier_clip.sv
tb/weighted_mean_outlier_clip_tb.sv
